@@ src/assert_macros.svh @@
// Assertion shorthands used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define ASSERT_DIS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

@@ src/stpc_pkg.sv @@
package stpc_pkg;

   // divider geometry: 64 bit dividend, 33 bit divisor, 48 quotient bits
   localparam int unsigned NUM_W   = 64;
   localparam int unsigned DEN_W   = 33;
   localparam int unsigned QBITS   = 48;
   localparam int unsigned DIV_LAT = QBITS + 1;

   // input reg, product stage, two dividers, saturate stage, six matrix stages
   localparam int unsigned PIPE_DEPTH = 2 * DIV_LAT + 9;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   // register indexes
   localparam logic [2:0] CSR_BASELINE = 3'd0;
   localparam logic [2:0] CSR_FOCAL    = 3'd1;
   localparam logic [2:0] CSR_NOISE_XX = 3'd2;
   localparam logic [2:0] CSR_NOISE_XY = 3'd3;
   localparam logic [2:0] CSR_NOISE_YX = 3'd4;
   localparam logic [2:0] CSR_NOISE_YY = 3'd5;

   // register reset values
   localparam logic [30:0]        RST_BASELINE = 31'd65536;
   localparam logic [30:0]        RST_FOCAL    = 31'd47920000;
   localparam logic signed [31:0] RST_NOISE_D  = 32'sd65536;
   localparam logic signed [31:0] RST_NOISE_O  = 32'sd0;

   // signed result from quotient magnitude, sign and overflow
   function automatic logic signed [31:0] sat_q(input logic ovf,
                                                input logic [QBITS-1:0] q,
                                                input logic neg);
      logic signed [31:0] r;
      if (neg) begin
         if (ovf || (q > 48'h0000_8000_0000)) r = Q_MIN;
         else r = (~q[31:0]) + 32'd1;
      end else begin
         if (ovf || (q[QBITS-1:31] != '0)) r = Q_MAX;
         else r = q[31:0];
      end
      return r;
   endfunction

   // floor((p + q) / 2^16) + off, saturated to 32 bits
   function automatic logic signed [31:0] mac_sat(input logic signed [63:0] p,
                                                  input logic signed [63:0] q,
                                                  input logic signed [31:0] off);
      logic [64:0] s;
      logic [48:0] t;
      logic [49:0] w;
      logic signed [31:0] r;
      s = {p[63], p} + {q[63], q};
      t = s[64:16];
      w = {t[48], t} + {{18{off[31]}}, off};
      if ((w[49:31] == '0) || (w[49:31] == '1)) r = w[31:0];
      else r = w[49] ? Q_MIN : Q_MAX;
      return r;
   endfunction

endpackage

@@ src/stpc_div.sv @@
// Pipelined unsigned restoring divider, one quotient bit per stage.
// First stage flags a quotient too large for the quotient width.
module stpc_div (
   input  logic                             clock,
   input  logic                             en,
   input  logic [stpc_pkg::NUM_W-1:0]       num,
   input  logic [stpc_pkg::DEN_W-1:0]       den,
   output logic [stpc_pkg::QBITS-1:0]       quot,
   output logic                             ovf
);

   localparam int unsigned QB = stpc_pkg::QBITS;
   localparam int unsigned DW = stpc_pkg::DEN_W;
   localparam int unsigned NW = stpc_pkg::NUM_W;

   logic [DW-1:0] rem_ff  [QB+1];
   logic [DW-1:0] rem_in  [QB+1];
   logic [QB-1:0] work_ff [QB+1];
   logic [QB-1:0] work_in [QB+1];
   logic [DW-1:0] den_ff  [QB+1];
   logic [DW-1:0] den_in  [QB+1];
   logic          ovf_ff  [QB+1];
   logic          ovf_in  [QB+1];

   // overflow check, then one compare and subtract per stage
   always_comb begin
      logic [DW:0] t;
      logic [DW:0] diff;
      logic        ge;
      ovf_in[0]  = {{(DW+QB-NW){1'b0}}, num} >= {den, {QB{1'b0}}};
      rem_in[0]  = {{(DW-(NW-QB)){1'b0}}, num[NW-1:QB]};
      work_in[0] = num[QB-1:0];
      den_in[0]  = den;
      for (int k = 0; k < QB; k++) begin
         t    = {rem_ff[k], work_ff[k][QB-1]};
         diff = t - {1'b0, den_ff[k]};
         ge   = (t >= {1'b0, den_ff[k]});
         rem_in[k+1]  = ge ? diff[DW-1:0] : t[DW-1:0];
         work_in[k+1] = {work_ff[k][QB-2:0], ge};
         den_in[k+1]  = den_ff[k];
         ovf_in[k+1]  = ovf_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= QB; k++) begin
            rem_ff[k]  <= rem_in[k];
            work_ff[k] <= work_in[k];
            den_ff[k]  <= den_in[k];
            ovf_ff[k]  <= ovf_in[k];
         end
      end
   end

   assign quot = work_ff[QB];
   assign ovf  = ovf_ff[QB];

endmodule

@@ src/stereo_triangulation_planar_cov.sv @@
// Throughput: one item per cycle unless stalled. An accepted item passes the
// input register, the product stage, two chained banks of 49-stage dividers,
// a saturate stage, six multiply/accumulate stages (all advancing together)
// and the output register. That register plus one skid entry hold results;
// req_tready drops only while the skid entry is full.
// Reset (synchronous): pipeline emptied, config registers back to defaults.
module stereo_triangulation_planar_cov (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // left_col, right_col, mean_row, offset_a, offset_b,
   // rot_00, rot_01, rot_10, rot_11 (32 bits each, lowest first)
   input  logic [287:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pos_a, pos_b, pos_height, cov_aa, cov_ab, cov_ba, cov_bb (lowest first)
   output logic [223:0] rsp_tdata,
   // zero_disparity
   output logic         rsp_tuser,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam int unsigned DL = stpc_pkg::DIV_LAT;
   localparam int unsigned PD = stpc_pkg::PIPE_DEPTH;

   typedef struct packed {
      logic signed [31:0] left_col, right_col, mean_row, offset_a, offset_b;
      logic signed [31:0] rot_00, rot_01, rot_10, rot_11;
   } req_type;

   typedef struct packed {
      logic signed [31:0] rot_00, rot_01, rot_10, rot_11, offset_a, offset_b;
      logic [31:0]        mag_d;
      logic               neg_px, neg_ph, neg_pz, neg_00, neg_01, neg_10, zero;
   } side_type;

   typedef struct packed {
      logic signed [31:0] px, ph, pz;
      logic [2:0]         jovf;   // right, left, baseline*focal
   } pq_type;

   typedef struct packed {
      logic signed [31:0] j00, j01, j10, j11, px, ph, pz;
      logic signed [31:0] rot_00, rot_01, rot_10, rot_11, offset_a, offset_b;
      logic               zero;
   } jst_type;

   typedef struct packed {
      logic signed [31:0] pa, pb, ph;
      logic               zero;
   } pos_type;

   typedef struct packed {
      logic               zero;
      logic signed [31:0] cov_bb, cov_ba, cov_ab, cov_aa, pos_height, pos_b, pos_a;
   } res_type;

   // configuration registers
   logic [30:0]        baseline_ff, focal_ff;
   logic signed [31:0] nxx_ff, nxy_ff, nyx_ff, nyy_ff;

   // pipeline control
   logic          en;
   logic          vld_ff [PD];
   logic          out_vld_ff, skid_vld_ff;
   res_type       out_ff, skid_ff;
   logic          pop;

   // stage registers
   req_type                         in_ff;
   logic [stpc_pkg::NUM_W-1:0]      num_ff [5];
   logic [stpc_pkg::NUM_W-1:0]      num_in [5];
   logic [stpc_pkg::DEN_W-1:0]      dd_ff, d2_ff, dd_in, d2_in;
   side_type                        side_ff, side_in;
   side_type                        sdly_ff [2*DL];
   pq_type                          pq_ff [DL];
   pq_type                          pq_in;
   logic [stpc_pkg::QBITS-1:0]      q1 [5];
   logic                            o1 [5];
   logic [stpc_pkg::QBITS-1:0]      q2 [3];
   logic                            o2 [3];
   logic [stpc_pkg::DEN_W-1:0]      den2;
   jst_type                         jst_ff, jst_in;
   logic signed [63:0]              m1_prod_ff [12];
   logic signed [63:0]              m1_prod_in [12];
   logic signed [31:0]              m1_ph_ff, m1_offa_ff, m1_offb_ff;
   logic                            m1_zero_ff;
   pos_type                         m2_pos_ff, m3_pos_ff, m4_pos_ff, m5_pos_ff;
   logic signed [31:0]              m2_a_ff [4];
   logic signed [31:0]              m3_a_ff [4];
   logic signed [31:0]              m4_a_ff [4];
   logic signed [31:0]              m4_b_ff [4];
   logic signed [63:0]              m3_prod_ff [8];
   logic signed [63:0]              m5_prod_ff [8];
   res_type                         m6_ff;

   assign en         = !skid_vld_ff;
   assign req_tready = en;
   assign pop        = out_vld_ff && rsp_tready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_ff <= stpc_pkg::RST_BASELINE;
         focal_ff    <= stpc_pkg::RST_FOCAL;
         nxx_ff      <= stpc_pkg::RST_NOISE_D;
         nxy_ff      <= stpc_pkg::RST_NOISE_O;
         nyx_ff      <= stpc_pkg::RST_NOISE_O;
         nyy_ff      <= stpc_pkg::RST_NOISE_D;
      end else if (csr_we) begin
         case (csr_index)
            stpc_pkg::CSR_BASELINE: baseline_ff <= csr_wdata[30:0];
            stpc_pkg::CSR_FOCAL:    focal_ff    <= csr_wdata[30:0];
            stpc_pkg::CSR_NOISE_XX: nxx_ff      <= csr_wdata;
            stpc_pkg::CSR_NOISE_XY: nxy_ff      <= csr_wdata;
            stpc_pkg::CSR_NOISE_YX: nyx_ff      <= csr_wdata;
            stpc_pkg::CSR_NOISE_YY: nyy_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   // disparity, magnitudes, signs and dividends
   always_comb begin
      logic signed [32:0] d_c, sum_c;
      logic [32:0]        md_c, ms_c;
      logic [31:0]        my_c, mxr_c, mxl_c;
      logic               bnz;
      d_c   = {in_ff.left_col[31], in_ff.left_col} - {in_ff.right_col[31], in_ff.right_col};
      sum_c = {in_ff.left_col[31], in_ff.left_col} + {in_ff.right_col[31], in_ff.right_col};
      md_c  = d_c[32] ? (~d_c + 33'd1) : d_c;
      ms_c  = sum_c[32] ? (~sum_c + 33'd1) : sum_c;
      my_c  = in_ff.mean_row[31] ? (~in_ff.mean_row + 32'd1) : in_ff.mean_row;
      mxr_c = in_ff.right_col[31] ? (~in_ff.right_col + 32'd1) : in_ff.right_col;
      mxl_c = in_ff.left_col[31] ? (~in_ff.left_col + 32'd1) : in_ff.left_col;
      bnz   = (baseline_ff != '0);

      num_in[0] = {33'd0, baseline_ff} * {31'd0, ms_c};
      num_in[1] = {33'd0, baseline_ff} * {32'd0, my_c};
      num_in[2] = {33'd0, baseline_ff} * {33'd0, focal_ff};
      num_in[3] = {33'd0, baseline_ff} * {32'd0, mxr_c};
      num_in[4] = {33'd0, baseline_ff} * {32'd0, mxl_c};
      dd_in     = {1'b0, md_c[31:0]};
      d2_in     = {md_c[31:0], 1'b0};

      side_in.rot_00   = in_ff.rot_00;
      side_in.rot_01   = in_ff.rot_01;
      side_in.rot_10   = in_ff.rot_10;
      side_in.rot_11   = in_ff.rot_11;
      side_in.offset_a = in_ff.offset_a;
      side_in.offset_b = in_ff.offset_b;
      side_in.mag_d    = md_c[31:0];
      side_in.neg_px   = (sum_c[32] && bnz) ^ d_c[32];
      side_in.neg_ph   = (in_ff.mean_row[31] && bnz) ^ d_c[32];
      side_in.neg_pz   = d_c[32];
      side_in.neg_00   = !in_ff.right_col[31] && (in_ff.right_col != '0) && bnz;
      side_in.neg_01   = in_ff.left_col[31] && bnz;
      side_in.neg_10   = bnz && (focal_ff != '0);
      side_in.zero     = (d_c == '0);
   end

   // first divisions: px, ph, pz and the first halves of the Jacobian
   stpc_div u_div_px (.clock(clock), .en(en), .num(num_ff[0]), .den(d2_ff),
                      .quot(q1[0]), .ovf(o1[0]));
   stpc_div u_div_ph (.clock(clock), .en(en), .num(num_ff[1]), .den(dd_ff),
                      .quot(q1[1]), .ovf(o1[1]));
   stpc_div u_div_bf (.clock(clock), .en(en), .num(num_ff[2]), .den(dd_ff),
                      .quot(q1[2]), .ovf(o1[2]));
   stpc_div u_div_xr (.clock(clock), .en(en), .num(num_ff[3]), .den(dd_ff),
                      .quot(q1[3]), .ovf(o1[3]));
   stpc_div u_div_xl (.clock(clock), .en(en), .num(num_ff[4]), .den(dd_ff),
                      .quot(q1[4]), .ovf(o1[4]));

   // saturate first results; pre-flag Jacobian quotients that are too big
   always_comb begin
      pq_in.px      = stpc_pkg::sat_q(o1[0], q1[0], sdly_ff[DL-1].neg_px);
      pq_in.ph      = stpc_pkg::sat_q(o1[1], q1[1], sdly_ff[DL-1].neg_ph);
      pq_in.pz      = stpc_pkg::sat_q(o1[2], q1[2], sdly_ff[DL-1].neg_pz);
      pq_in.jovf[0] = o1[3] || q1[3][stpc_pkg::QBITS-1];
      pq_in.jovf[1] = o1[4] || q1[4][stpc_pkg::QBITS-1];
      pq_in.jovf[2] = o1[2] || q1[2][stpc_pkg::QBITS-1];
   end

   assign den2 = {1'b0, sdly_ff[DL-1].mag_d};

   // second divisions: (q1 * 2^16) / |d|
   stpc_div u_div2_xr (.clock(clock), .en(en), .num({q1[3], 16'd0}), .den(den2),
                       .quot(q2[0]), .ovf(o2[0]));
   stpc_div u_div2_xl (.clock(clock), .en(en), .num({q1[4], 16'd0}), .den(den2),
                       .quot(q2[1]), .ovf(o2[1]));
   stpc_div u_div2_bf (.clock(clock), .en(en), .num({q1[2], 16'd0}), .den(den2),
                       .quot(q2[2]), .ovf(o2[2]));

   // Jacobian saturation and alignment with the pose
   always_comb begin
      jst_in.j00 = stpc_pkg::sat_q(pq_ff[DL-1].jovf[0] || o2[0], q2[0],
                                   sdly_ff[2*DL-1].neg_00);
      jst_in.j01 = stpc_pkg::sat_q(pq_ff[DL-1].jovf[1] || o2[1], q2[1],
                                   sdly_ff[2*DL-1].neg_01);
      jst_in.j10 = stpc_pkg::sat_q(pq_ff[DL-1].jovf[2] || o2[2], q2[2],
                                   sdly_ff[2*DL-1].neg_10);
      jst_in.j11 = stpc_pkg::sat_q(pq_ff[DL-1].jovf[2] || o2[2], q2[2], 1'b0);
      jst_in.px       = pq_ff[DL-1].px;
      jst_in.ph       = pq_ff[DL-1].ph;
      jst_in.pz       = pq_ff[DL-1].pz;
      jst_in.rot_00   = sdly_ff[2*DL-1].rot_00;
      jst_in.rot_01   = sdly_ff[2*DL-1].rot_01;
      jst_in.rot_10   = sdly_ff[2*DL-1].rot_10;
      jst_in.rot_11   = sdly_ff[2*DL-1].rot_11;
      jst_in.offset_a = sdly_ff[2*DL-1].offset_a;
      jst_in.offset_b = sdly_ff[2*DL-1].offset_b;
      jst_in.zero     = sdly_ff[2*DL-1].zero;
   end

   // rotation products for position and A = R*J
   always_comb begin
      m1_prod_in[0]  = jst_ff.rot_00 * jst_ff.px;
      m1_prod_in[1]  = jst_ff.rot_01 * jst_ff.pz;
      m1_prod_in[2]  = jst_ff.rot_10 * jst_ff.px;
      m1_prod_in[3]  = jst_ff.rot_11 * jst_ff.pz;
      m1_prod_in[4]  = jst_ff.rot_00 * jst_ff.j00;
      m1_prod_in[5]  = jst_ff.rot_01 * jst_ff.j10;
      m1_prod_in[6]  = jst_ff.rot_00 * jst_ff.j01;
      m1_prod_in[7]  = jst_ff.rot_01 * jst_ff.j11;
      m1_prod_in[8]  = jst_ff.rot_10 * jst_ff.j00;
      m1_prod_in[9]  = jst_ff.rot_11 * jst_ff.j10;
      m1_prod_in[10] = jst_ff.rot_10 * jst_ff.j01;
      m1_prod_in[11] = jst_ff.rot_11 * jst_ff.j11;
   end

   // data path registers, all held on a stall
   always_ff @(posedge clock) begin
      if (en) begin
         in_ff.left_col  <= req_tdata[31:0];
         in_ff.right_col <= req_tdata[63:32];
         in_ff.mean_row  <= req_tdata[95:64];
         in_ff.offset_a  <= req_tdata[127:96];
         in_ff.offset_b  <= req_tdata[159:128];
         in_ff.rot_00    <= req_tdata[191:160];
         in_ff.rot_01    <= req_tdata[223:192];
         in_ff.rot_10    <= req_tdata[255:224];
         in_ff.rot_11    <= req_tdata[287:256];

         for (int i = 0; i < 5; i++) num_ff[i] <= num_in[i];
         dd_ff   <= dd_in;
         d2_ff   <= d2_in;
         side_ff <= side_in;

         sdly_ff[0] <= side_ff;
         for (int i = 1; i < 2*DL; i++) sdly_ff[i] <= sdly_ff[i-1];
         pq_ff[0] <= pq_in;
         for (int i = 1; i < DL; i++) pq_ff[i] <= pq_ff[i-1];

         jst_ff <= jst_in;

         // stage m1
         for (int i = 0; i < 12; i++) m1_prod_ff[i] <= m1_prod_in[i];
         m1_ph_ff   <= jst_ff.ph;
         m1_offa_ff <= jst_ff.offset_a;
         m1_offb_ff <= jst_ff.offset_b;
         m1_zero_ff <= jst_ff.zero;

         // stage m2: position and A
         m2_pos_ff.pa   <= stpc_pkg::mac_sat(m1_prod_ff[0], m1_prod_ff[1], m1_offa_ff);
         m2_pos_ff.pb   <= stpc_pkg::mac_sat(m1_prod_ff[2], m1_prod_ff[3], m1_offb_ff);
         m2_pos_ff.ph   <= m1_ph_ff;
         m2_pos_ff.zero <= m1_zero_ff;
         m2_a_ff[0] <= stpc_pkg::mac_sat(m1_prod_ff[4], m1_prod_ff[5], 32'sd0);
         m2_a_ff[1] <= stpc_pkg::mac_sat(m1_prod_ff[6], m1_prod_ff[7], 32'sd0);
         m2_a_ff[2] <= stpc_pkg::mac_sat(m1_prod_ff[8], m1_prod_ff[9], 32'sd0);
         m2_a_ff[3] <= stpc_pkg::mac_sat(m1_prod_ff[10], m1_prod_ff[11], 32'sd0);

         // stage m3: A*N products
         m3_prod_ff[0] <= m2_a_ff[0] * nxx_ff;
         m3_prod_ff[1] <= m2_a_ff[1] * nyx_ff;
         m3_prod_ff[2] <= m2_a_ff[0] * nxy_ff;
         m3_prod_ff[3] <= m2_a_ff[1] * nyy_ff;
         m3_prod_ff[4] <= m2_a_ff[2] * nxx_ff;
         m3_prod_ff[5] <= m2_a_ff[3] * nyx_ff;
         m3_prod_ff[6] <= m2_a_ff[2] * nxy_ff;
         m3_prod_ff[7] <= m2_a_ff[3] * nyy_ff;
         for (int i = 0; i < 4; i++) m3_a_ff[i] <= m2_a_ff[i];
         m3_pos_ff <= m2_pos_ff;

         // stage m4: B
         for (int i = 0; i < 4; i++) begin
            m4_b_ff[i] <= stpc_pkg::mac_sat(m3_prod_ff[2*i], m3_prod_ff[2*i+1], 32'sd0);
            m4_a_ff[i] <= m3_a_ff[i];
         end
         m4_pos_ff <= m3_pos_ff;

         // stage m5: B*A^T products
         m5_prod_ff[0] <= m4_b_ff[0] * m4_a_ff[0];
         m5_prod_ff[1] <= m4_b_ff[1] * m4_a_ff[1];
         m5_prod_ff[2] <= m4_b_ff[0] * m4_a_ff[2];
         m5_prod_ff[3] <= m4_b_ff[1] * m4_a_ff[3];
         m5_prod_ff[4] <= m4_b_ff[2] * m4_a_ff[0];
         m5_prod_ff[5] <= m4_b_ff[3] * m4_a_ff[1];
         m5_prod_ff[6] <= m4_b_ff[2] * m4_a_ff[2];
         m5_prod_ff[7] <= m4_b_ff[3] * m4_a_ff[3];
         m5_pos_ff <= m4_pos_ff;

         // stage m6: covariance, zero disparity forces saturation
         if (m5_pos_ff.zero) begin
            m6_ff.zero       <= 1'b1;
            m6_ff.pos_a      <= stpc_pkg::Q_MAX;
            m6_ff.pos_b      <= stpc_pkg::Q_MAX;
            m6_ff.pos_height <= stpc_pkg::Q_MAX;
            m6_ff.cov_aa     <= stpc_pkg::Q_MAX;
            m6_ff.cov_ab     <= stpc_pkg::Q_MAX;
            m6_ff.cov_ba     <= stpc_pkg::Q_MAX;
            m6_ff.cov_bb     <= stpc_pkg::Q_MAX;
         end else begin
            m6_ff.zero       <= 1'b0;
            m6_ff.pos_a      <= m5_pos_ff.pa;
            m6_ff.pos_b      <= m5_pos_ff.pb;
            m6_ff.pos_height <= m5_pos_ff.ph;
            m6_ff.cov_aa <= stpc_pkg::mac_sat(m5_prod_ff[0], m5_prod_ff[1], 32'sd0);
            m6_ff.cov_ab <= stpc_pkg::mac_sat(m5_prod_ff[2], m5_prod_ff[3], 32'sd0);
            m6_ff.cov_ba <= stpc_pkg::mac_sat(m5_prod_ff[4], m5_prod_ff[5], 32'sd0);
            m6_ff.cov_bb <= stpc_pkg::mac_sat(m5_prod_ff[6], m5_prod_ff[7], 32'sd0);
         end
      end
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PD; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < PD; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // output register with one skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (pop) begin
            out_ff      <= skid_ff;
            skid_vld_ff <= 1'b0;
         end
      end else if (vld_ff[PD-1]) begin
         if (!out_vld_ff || pop) begin
            out_ff     <= m6_ff;
            out_vld_ff <= 1'b1;
         end else begin
            skid_ff     <= m6_ff;
            skid_vld_ff <= 1'b1;
         end
      end else if (pop) begin
         out_vld_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_ff.zero;
   assign rsp_tdata  = {out_ff.cov_bb, out_ff.cov_ba, out_ff.cov_ab, out_ff.cov_aa,
                        out_ff.pos_height, out_ff.pos_b, out_ff.pos_a};

endmodule

@@ src/stpc_check.sv @@
`include "assert_macros.svh"

// Port-level checks for the triangulation block.
module stpc_check (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [223:0] rsp_tdata,
   input logic         rsp_tuser
);

   // a stalled result stays offered
   `ASSERT_DIS(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)

   // and keeps its value
   `ASSERT_DIS(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))

   // zero disparity flags a fully saturated item
   `ASSERT_DIS(a_zero_sat, clock, reset, rsp_tvalid && rsp_tuser |-> rsp_tdata == {7{32'h7FFF_FFFF}})

   // reset empties the output side and opens the input
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid && req_tready)

endmodule

bind stereo_triangulation_planar_cov stpc_check u_stpc_check (.*);
